[design/etsu_pkg.sv]
// ---------------------------------------------------------------------------
// etsu_pkg
// Shared types, codes and defaults for the event timer scheduler.
// ---------------------------------------------------------------------------
`default_nettype none
package etsu_pkg;
   localparam int SLOTS_DEFAULT = 16;
   localparam int TIME_W        = 32;
   localparam int TAG_W         = 8;
   localparam int DELTA_W       = 16;
   localparam int DAYLEN_W      = 20;
   localparam int KIND_W        = 2;
   localparam logic [DAYLEN_W-1:0] DAY_LENGTH_RESET = DAYLEN_W'(86400);
   localparam logic [TIME_W-1:0]   SAT_TIME = '1;

   localparam logic CMD_SCHEDULE = 1'b0;
   localparam logic CMD_TICK     = 1'b1;

   localparam logic [KIND_W-1:0] KIND_SCHEDULED = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REJECTED  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FIRED     = 2'd2;
   localparam logic [KIND_W-1:0] KIND_DONE      = 2'd3;

   typedef struct packed {
      logic [TIME_W-1:0] due;
      logic [TIME_W-1:0] interval;
      logic [TAG_W-1:0]  tag;
   } entry_type;
endpackage
`default_nettype wire

[design/etsu_ifs.sv]
// ---------------------------------------------------------------------------
// etsu interfaces
// Valid/ready channels for requests, responses and the day length register.
// ---------------------------------------------------------------------------
`default_nettype none
interface etsu_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [31:0] due_time;
   logic [31:0] interval;
   logic        in_days;
   logic [7:0]  tag;
   logic [15:0] delta;
   modport source (output valid, command, due_time, interval, in_days, tag, delta,
                   input ready);
   modport sink   (input valid, command, due_time, interval, in_days, tag, delta,
                   output ready);
endinterface

interface etsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] fired_tag;
   logic       last;
   modport source (output valid, kind, fired_tag, last, input ready);
   modport sink   (input valid, kind, fired_tag, last, output ready);
endinterface

interface etsu_csr_if;
   logic        valid;
   logic        ready;
   logic [19:0] day_length;
   modport source (output valid, day_length, input ready);
   modport sink   (input valid, day_length, output ready);
endinterface
`default_nettype wire

[design/etsu_mem.sv]
// ---------------------------------------------------------------------------
// etsu_mem
// Timer list storage: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module etsu_mem
   import etsu_pkg::*;
#(
   parameter int DEPTH = SLOTS_DEFAULT,
   parameter int AW    = 4
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire entry_type     wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output entry_type          rd_data
);
   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

[design/etsu_scale.sv]
// ---------------------------------------------------------------------------
// etsu_scale
// Saturating 32 x 20 multiply that turns a count of days into time units.
// ---------------------------------------------------------------------------
`default_nettype none
module etsu_scale
   import etsu_pkg::*;
(
   input  wire logic [TIME_W-1:0]   value,
   input  wire logic [DAYLEN_W-1:0] day_length,
   output logic      [TIME_W-1:0]   scaled
);
   logic [TIME_W+DAYLEN_W-1:0] product;

   always_comb begin
      product = value * day_length;
      scaled  = (|product[TIME_W+DAYLEN_W-1:TIME_W]) ? SAT_TIME : product[TIME_W-1:0];
   end
endmodule
`default_nettype wire

[design/event_timer_scheduler_unit.sv]
// ---------------------------------------------------------------------------
// event_timer_scheduler_unit
// Timer list in insertion order with schedule and tick commands, list kept in a RAM.
// ---------------------------------------------------------------------------
//  channel   | direction | content
//  req_chan  | in        | command, due_time, interval, in_days, tag, delta
//  rsp_chan  | out       | kind, fired_tag, last
//  csr_chan  | in        | day_length write
//
//  Schedule: RAM write, then response; day scaling first adds two passes of one shared multiplier.
//  Tick: each timer takes one RAM read and one evaluate step, held while a fire beat
//  cannot be placed; survivors are written back compacted behind the read pointer.
//  Reset clears the total time and empties the list; no clearing pass.
//  A full response register holds the sequencer in S_EMIT, or in S_EVAL on a firing timer, until the beat is taken.
// ---------------------------------------------------------------------------
`default_nettype none
module event_timer_scheduler_unit
   import etsu_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   etsu_req_if.sink   req_chan,
   etsu_rsp_if.source rsp_chan,
   etsu_csr_if.sink   csr_chan
);
   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_MUL_DUE = 3'd1;
   localparam logic [2:0] S_MUL_IVL = 3'd2;
   localparam logic [2:0] S_WRITE   = 3'd3;
   localparam logic [2:0] S_EMIT    = 3'd4;
   localparam logic [2:0] S_TICK    = 3'd5;
   localparam logic [2:0] S_RD      = 3'd6;
   localparam logic [2:0] S_EVAL    = 3'd7;

   logic [2:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       rptr_ff, rptr_in;
   logic [CW-1:0]       wptr_ff, wptr_in;
   logic [TIME_W-1:0]   total_ff, total_in;
   logic [DAYLEN_W-1:0] daylen_ff;
   logic [TIME_W-1:0]   due_ff, due_in;
   logic [TIME_W-1:0]   ivl_ff, ivl_in;
   logic [TAG_W-1:0]    tag_ff;
   logic [DELTA_W-1:0]  delta_ff;
   logic [KIND_W-1:0]   pend_kind_ff, pend_kind_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [TAG_W-1:0]    rsp_tag_ff, rsp_tag_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                out_free, req_acc;
   logic [TIME_W-1:0]   mul_in, mul_out;
   logic [TIME_W:0]     tick_sum, due_sum;
   logic                mem_wr_en, mem_rd_en, fire;
   logic [AW-1:0]       mem_wr_addr;
   entry_type           mem_wr_data, rd_entry;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_acc = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign mul_in = (state_ff == S_MUL_DUE) ? due_ff : ivl_ff;

   etsu_scale u_scale (
      .value      (mul_in),
      .day_length (daylen_ff),
      .scaled     (mul_out)
   );

   etsu_mem #(.DEPTH(SLOTS), .AW(AW)) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (rptr_ff[AW-1:0]),
      .rd_data (rd_entry)
   );

   assign tick_sum = {1'b0, total_ff} + {{(TIME_W+1-DELTA_W){1'b0}}, delta_ff};
   assign due_sum  = {1'b0, rd_entry.due} + {1'b0, rd_entry.interval};
   assign fire     = (total_ff >= rd_entry.due);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rptr_in      = rptr_ff;
      wptr_in      = wptr_ff;
      total_in     = total_ff;
      due_in       = due_ff;
      ivl_in       = ivl_ff;
      pend_kind_in = pend_kind_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_last_in  = rsp_last_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = count_ff[AW-1:0];
      mem_wr_data  = '{due: due_ff, interval: ivl_ff, tag: tag_ff};
      mem_rd_en    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               due_in = req_chan.due_time;
               ivl_in = req_chan.interval;
               if (req_chan.command == CMD_TICK) begin
                  state_in = S_TICK;
               end else if (count_ff >= SLOTS_C) begin
                  pend_kind_in = KIND_REJECTED;
                  state_in     = S_EMIT;
               end else if (req_chan.in_days) begin
                  state_in = S_MUL_DUE;
               end else begin
                  state_in = S_WRITE;
               end
            end
         end
         S_MUL_DUE: begin
            due_in   = mul_out;
            state_in = S_MUL_IVL;
         end
         S_MUL_IVL: begin
            ivl_in   = mul_out;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            mem_wr_en    = 1'b1;
            count_in     = count_ff + 1'b1;
            pend_kind_in = KIND_SCHEDULED;
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = pend_kind_ff;
               rsp_tag_in   = '0;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_TICK: begin
            total_in = tick_sum[TIME_W] ? SAT_TIME : tick_sum[TIME_W-1:0];
            rptr_in  = '0;
            wptr_in  = '0;
            state_in = S_RD;
         end
         S_RD: begin
            if (rptr_ff < count_ff) begin
               mem_rd_en = 1'b1;
               state_in  = S_EVAL;
            end else begin
               count_in     = wptr_ff;
               pend_kind_in = KIND_DONE;
               state_in     = S_EMIT;
            end
         end
         S_EVAL: begin
            // hold while a fire beat cannot be placed
            if (!fire || out_free) begin
               if (fire) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_FIRED;
                  rsp_tag_in   = rd_entry.tag;
                  rsp_last_in  = 1'b0;
               end
               // drop fired one-shots, compact the rest down to the write pointer
               if (!fire || (rd_entry.interval != '0)) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = wptr_ff[AW-1:0];
                  mem_wr_data = rd_entry;
                  if (fire) begin
                     mem_wr_data.due = due_sum[TIME_W] ? SAT_TIME : due_sum[TIME_W-1:0];
                  end
                  wptr_in = wptr_ff + 1'b1;
               end
               rptr_in  = rptr_ff + 1'b1;
               state_in = S_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rptr_ff      <= '0;
         wptr_ff      <= '0;
         total_ff     <= '0;
         daylen_ff    <= DAY_LENGTH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rptr_ff      <= rptr_in;
         wptr_ff      <= wptr_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid && csr_chan.ready) begin
            daylen_ff <= csr_chan.day_length;
         end
      end
   end

   always_ff @(posedge clock) begin
      due_ff       <= due_in;
      ivl_ff       <= ivl_in;
      pend_kind_ff <= pend_kind_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_last_ff  <= rsp_last_in;
      if (req_acc) begin
         tag_ff   <= req_chan.tag;
         delta_ff <= req_chan.delta;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.kind      = rsp_kind_ff;
   assign rsp_chan.fired_tag = rsp_tag_ff;
   assign rsp_chan.last      = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= SLOTS_C)
      else $error("timer count exceeds slot count");

   a_wptr_behind: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD || state_ff == S_EVAL) |-> (wptr_ff <= rptr_ff))
      else $error("compaction write pointer passed read pointer");

   a_tick_no_growth: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD && rptr_ff >= count_ff) |=> (count_ff <= $past(count_ff)))
      else $error("tick grew the timer list");

   a_fire_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_FIRED) |-> !rsp_last_ff)
      else $error("fire beat marked last");
endmodule
`default_nettype wire
